// ===== hw/rtl/cbim_pkg.sv =====
// Shared types, codes and constants of the cartridge bank and IRQ mapper.
package cbim_pkg;

   // Request kinds
   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_TICK  = 1'b1;

   // Mirroring codes
   localparam logic [1:0] MIRROR_VERTICAL   = 2'd0;
   localparam logic [1:0] MIRROR_HORIZONTAL = 2'd1;
   localparam logic [1:0] MIRROR_SINGLE_A   = 2'd2;
   localparam logic [1:0] MIRROR_SINGLE_B   = 2'd3;

   // Board layouts
   localparam logic [1:0] BOARD_SIMPLE = 2'd0;
   localparam logic [1:0] BOARD_CHRRAM = 2'd1;
   localparam logic [1:0] BOARD_FINE   = 2'd2;

   // CPU register addresses
   localparam logic [15:0] ADDR_MODE      = 16'h42FE;
   localparam logic [15:0] ADDR_MIRROR    = 16'h42FF;
   localparam logic [15:0] ADDR_IRQ_EN    = 16'h4501;
   localparam logic [15:0] ADDR_IRQ_LO    = 16'h4502;
   localparam logic [15:0] ADDR_IRQ_HI    = 16'h4503;
   localparam logic [13:0] ADDR_PRG8_BASE = 14'h1141;  // 4504..4507 >> 2
   localparam logic [12:0] ADDR_CHR1_BASE = 13'h08A2;  // 4510..4517 >> 3

   // Configuration register indexes
   localparam logic [1:0] CSR_BOARD_TYPE = 2'd0;
   localparam logic [1:0] CSR_IRQ_TARGET = 2'd1;
   localparam logic [1:0] CSR_CHR_IS_RAM = 2'd2;
   localparam int unsigned CSR_ADDR_WIDTH = 4;

   // Configuration reset values
   localparam logic [1:0]  BOARD_TYPE_RESET = BOARD_SIMPLE;
   localparam logic [15:0] IRQ_TARGET_RESET = 16'hCFFF;
   localparam logic        CHR_IS_RAM_RESET = 1'b0;

   typedef enum logic [2:0] {
      UPD_NONE  = 3'd0,
      UPD_PRG16 = 3'd1,
      UPD_CHR8  = 3'd2,
      UPD_PRG8  = 3'd3,
      UPD_CHR1  = 3'd4
   } update_kind_type;

   typedef struct packed {
      logic        mode;
      logic [15:0] address;
      logic [7:0]  data;
   } req_type;

   typedef struct packed {
      logic            irq_line;
      logic [1:0]      mirroring;
      update_kind_type update_kind;
      logic [2:0]      update_slot;
      logic [7:0]      bank_number;
      logic            chr_source;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  board_type;
      logic [15:0] irq_target;
      logic        chr_is_ram;
   } cfg_type;

   typedef struct packed {
      logic [15:0] irq_count;
      logic        irq_enable;
      logic        irq_pending;
      logic        ram_mode;
      logic [1:0]  mirror_state;
   } state_type;

endpackage

// ===== hw/rtl/cbim_step.sv =====
// Per-request decode: next mapper state and the bank update result.
module cbim_step (
   input  cbim_pkg::cfg_type   cfg,
   input  cbim_pkg::state_type state,
   input  cbim_pkg::req_type   req_item,
   output cbim_pkg::state_type state_next,
   output cbim_pkg::rsp_type   rsp_item
);

   logic                      has_irq;
   logic                      high_addr;
   cbim_pkg::update_kind_type kind;
   logic [2:0]                slot;
   logic [7:0]                bank;
   logic                      src;

   assign has_irq   = (cfg.board_type != cbim_pkg::BOARD_SIMPLE);
   assign high_addr = req_item.address[15];

   always_comb begin
      state_next = state;
      kind       = cbim_pkg::UPD_NONE;
      slot       = 3'd0;
      bank       = 8'd0;
      src        = 1'b0;

      if (req_item.mode == cbim_pkg::MODE_TICK) begin
         // Advance the IRQ counter; fire and disable on a target match
         if (has_irq && state.irq_enable) begin
            if (state.irq_count == cfg.irq_target) begin
               state_next.irq_count   = 16'd0;
               state_next.irq_enable  = 1'b0;
               state_next.irq_pending = 1'b1;
            end else begin
               state_next.irq_count = state.irq_count + 16'd1;
            end
         end
      end else begin
         // Decode the CPU write; the first matching register wins
         priority if (req_item.address == cbim_pkg::ADDR_MODE) begin
            state_next.ram_mode     = ~req_item.data[7];
            state_next.mirror_state = req_item.data[4] ? cbim_pkg::MIRROR_SINGLE_B
                                                       : cbim_pkg::MIRROR_SINGLE_A;
         end else if (req_item.address == cbim_pkg::ADDR_MIRROR) begin
            state_next.mirror_state = req_item.data[4] ? cbim_pkg::MIRROR_HORIZONTAL
                                                       : cbim_pkg::MIRROR_VERTICAL;
         end else if (has_irq && req_item.address == cbim_pkg::ADDR_IRQ_EN) begin
            state_next.irq_enable  = req_item.data[0];
            state_next.irq_pending = 1'b0;
         end else if (has_irq && req_item.address == cbim_pkg::ADDR_IRQ_LO) begin
            state_next.irq_count[7:0] = req_item.data;
         end else if (has_irq && req_item.address == cbim_pkg::ADDR_IRQ_HI) begin
            state_next.irq_count[15:8] = req_item.data;
            state_next.irq_enable      = 1'b1;
            state_next.irq_pending     = 1'b0;
         end else if (cfg.board_type == cbim_pkg::BOARD_SIMPLE && high_addr) begin
            // Combined PRG 16K and CHR 8K switch; CHR bank rides in the slot field
            kind = cbim_pkg::UPD_PRG16;
            bank = {3'd0, req_item.data[7:3]};
            slot = req_item.data[2:0];
         end else if (cfg.board_type == cbim_pkg::BOARD_CHRRAM && high_addr) begin
            if (state.ram_mode || cfg.chr_is_ram) begin
               kind = cbim_pkg::UPD_PRG16;
               bank = {2'd0, req_item.data[7:2]};
               slot = {1'b0, req_item.data[1:0]};
            end else begin
               kind = cbim_pkg::UPD_CHR8;
               bank = req_item.data;
            end
            src = state.ram_mode;
         end else if (cfg.board_type == cbim_pkg::BOARD_FINE &&
                      req_item.address[15:2] == cbim_pkg::ADDR_PRG8_BASE) begin
            kind = cbim_pkg::UPD_PRG8;
            slot = {1'b0, req_item.address[1:0]};
            bank = req_item.data;
         end else if (cfg.board_type == cbim_pkg::BOARD_FINE &&
                      req_item.address[15:3] == cbim_pkg::ADDR_CHR1_BASE) begin
            kind = cbim_pkg::UPD_CHR1;
            slot = req_item.address[2:0];
            bank = req_item.data;
         end else begin
            // Unmapped write: leave everything as is
            kind = cbim_pkg::UPD_NONE;
         end
      end
   end

   // Report levels after this request
   always_comb begin
      rsp_item.irq_line    = state_next.irq_pending;
      rsp_item.mirroring   = state_next.mirror_state;
      rsp_item.update_kind = kind;
      rsp_item.update_slot = slot;
      rsp_item.bank_number = bank;
      rsp_item.chr_source  = src;
   end

endmodule

// ===== hw/rtl/cbim_out_buf.sv =====
// Two-entry result buffer: output register plus skid register.
module cbim_out_buf (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  cbim_pkg::rsp_type push_item,
   output logic              can_push,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cbim_pkg::rsp_type rsp_item
);

   logic              out_valid_ff,  out_valid_in;
   logic              skid_valid_ff, skid_valid_in;
   cbim_pkg::rsp_type out_ff,  out_in;
   cbim_pkg::rsp_type skid_ff, skid_in;
   logic              pop;

   assign pop       = out_valid_ff && rsp_ready;
   assign can_push  = !skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_ff;

   // Refill the output from the skid first, else from a new request
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!out_valid_ff || pop) begin
         out_in       = push_item;
         out_valid_in = push;
      end else if (push) begin
         skid_in       = push_item;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Hold payload without reset
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

endmodule

// ===== hw/rtl/cartridge_bank_irq_mapper_core.sv =====
// Top level of the cartridge bank and IRQ mapper.
//
// Each request on the req_ channel is either a CPU write (address, data)
// or one CPU clock tick. Every request yields exactly one result on the
// rsp_ channel: the IRQ line level and mirroring after the request, plus
// at most one PRG or CHR bank window update.
// The request is decoded against the mapper state, its result registered in
// the output register, or in the skid register while that stalls; a free
// output offers it on the cycle after acceptance. One request per cycle is
// sustained while results are taken; the figure is set by the single state
// update path from the request ports to the state and output registers.
// A skid register behind the output register keeps req_ready high while
// one result waits; req_ready drops only when both entries are full, and
// results are never dropped or reordered while the receiver stalls.
// Synchronous reset clears the IRQ counter, enable, pending line, RAM mode
// and mirroring (vertical), empties the result buffer and loads the
// configuration defaults (board 0, target CFFF, CHR source zero ROM).
// Configuration is written through the APB-style port at 0, 4 and 8.
module cartridge_bank_irq_mapper_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  cbim_pkg::req_type                     req_item,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output cbim_pkg::rsp_type                     rsp_item,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [cbim_pkg::CSR_ADDR_WIDTH-1:0]   paddr,
   input  logic [31:0]                           pwdata,
   output logic [31:0]                           prdata,
   output logic                                  pready
);

   cbim_pkg::cfg_type   cfg_ff,   cfg_in;
   cbim_pkg::state_type state_ff, state_in;
   cbim_pkg::rsp_type   step_rsp;
   logic                accept;
   logic                csr_write;
   logic [1:0]          csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = paddr[3:2];
   assign accept    = req_valid && req_ready;

   // Load the addressed configuration register
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            cbim_pkg::CSR_BOARD_TYPE: cfg_in.board_type = pwdata[1:0];
            cbim_pkg::CSR_IRQ_TARGET: cfg_in.irq_target = pwdata[15:0];
            cbim_pkg::CSR_CHR_IS_RAM: cfg_in.chr_is_ram = pwdata[0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   // Return the addressed configuration register
   always_comb begin
      unique case (csr_index)
         cbim_pkg::CSR_BOARD_TYPE: prdata = {30'd0, cfg_ff.board_type};
         cbim_pkg::CSR_IRQ_TARGET: prdata = {16'd0, cfg_ff.irq_target};
         cbim_pkg::CSR_CHR_IS_RAM: prdata = {31'd0, cfg_ff.chr_is_ram};
         default:                  prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.board_type <= cbim_pkg::BOARD_TYPE_RESET;
         cfg_ff.irq_target <= cbim_pkg::IRQ_TARGET_RESET;
         cfg_ff.chr_is_ram <= cbim_pkg::CHR_IS_RAM_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cbim_step u_step (
      .cfg        (cfg_ff),
      .state      (state_ff),
      .req_item   (req_item),
      .state_next (state_in),
      .rsp_item   (step_rsp)
   );

   // Advance mapper state on each accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.irq_count    <= 16'd0;
         state_ff.irq_enable   <= 1'b0;
         state_ff.irq_pending  <= 1'b0;
         state_ff.ram_mode     <= 1'b0;
         state_ff.mirror_state <= cbim_pkg::MIRROR_VERTICAL;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   cbim_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_item (step_rsp),
      .can_push  (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

endmodule

// ===== hw/rtl/cbim_checker.sv =====
// Port-level checks of the mapper core and their bind to the top level.
module cbim_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input cbim_pkg::rsp_type rsp_item
);

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_item)))
      else $error("stalled result changed or dropped");

   // Reset empties the result buffer
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered after reset");

   // A result is on offer on the cycle after an acceptance
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> rsp_valid)
      else $error("accepted request produced no result");

   // A result without update carries zero slot, bank and source
   a_no_update_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.update_kind == cbim_pkg::UPD_NONE) |->
      (rsp_item.update_slot == 3'd0 && rsp_item.bank_number == 8'd0 &&
       rsp_item.chr_source == 1'b0))
      else $error("no-update result carries bank fields");

   // Only a PRG16 or CHR8 switch of the CHR RAM board has a source
   a_src_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.chr_source) |->
      (rsp_item.update_kind == cbim_pkg::UPD_PRG16 ||
       rsp_item.update_kind == cbim_pkg::UPD_CHR8))
      else $error("CHR source reported on a fine bank update");

endmodule

bind cartridge_bank_irq_mapper_core cbim_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_item  (rsp_item)
);

// ===== test/cartridge_bank_irq_mapper_core_tb.sv =====
// Self-checking testbench for the cartridge bank and IRQ mapper core.
`timescale 1ns / 1ps

module cartridge_bank_irq_mapper_core_tb;
   import cbim_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_item  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_item;

   logic                      psel    = 1'b0;
   logic                      penable = 1'b0;
   logic                      pwrite  = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] paddr   = '0;
   logic [31:0]               pwdata  = '0;
   logic [31:0]               prdata;
   logic                      pready;

   cartridge_bank_irq_mapper_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   // Free-running clock
   initial begin
      forever #6 clock = ~clock;
   end

   // Hard stop in case the block hangs
   initial begin
      #3_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // Shadow of the configuration registers
   logic [1:0]  cfg_board   = BOARD_TYPE_RESET;
   logic [15:0] cfg_target  = IRQ_TARGET_RESET;
   logic        cfg_chr_ram = CHR_IS_RAM_RESET;

   // Predicted mapper state
   logic [15:0] pred_count    = '0;
   logic        pred_enable   = 1'b0;
   logic        pred_line     = 1'b0;
   logic        pred_ram_mode = 1'b0;
   logic [1:0]  pred_mirror   = MIRROR_VERTICAL;

   req_type pending_cpu_ops[$];
   rsp_type expected_reports[$];
   int      queued_ops    = 0;
   int      mismatches    = 0;
   int      reports_seen  = 0;
   int      stall_left    = 0;
   bit      stall_done    = 1'b0;
   int      cycle_count   = 0;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Random idle decision; a long calm window recurs with no idling at all
   function automatic bit take_break();
      if ((cycle_count % 3000) < 800)
         return 1'b0;
      return $urandom_range(0, 99) < 9;
   endfunction

   // Advance the predicted state by one request and build its bank report
   function automatic rsp_type predict_mapper(input req_type op);
      rsp_type rep;
      rep = '0;
      if (op.mode == MODE_TICK) begin
         if (cfg_board != BOARD_SIMPLE && pred_enable) begin
            if (pred_count == cfg_target) begin
               pred_count  = '0;
               pred_enable = 1'b0;
               pred_line   = 1'b1;
            end else begin
               pred_count = pred_count + 16'd1;
            end
         end
      end else if (op.address == ADDR_MODE) begin
         pred_ram_mode = ~op.data[7];
         pred_mirror   = op.data[4] ? MIRROR_SINGLE_B : MIRROR_SINGLE_A;
      end else if (op.address == ADDR_MIRROR) begin
         pred_mirror = op.data[4] ? MIRROR_HORIZONTAL : MIRROR_VERTICAL;
      end else if (cfg_board != BOARD_SIMPLE && op.address == ADDR_IRQ_EN) begin
         pred_enable = op.data[0];
         pred_line   = 1'b0;
      end else if (cfg_board != BOARD_SIMPLE && op.address == ADDR_IRQ_LO) begin
         pred_count[7:0] = op.data;
      end else if (cfg_board != BOARD_SIMPLE && op.address == ADDR_IRQ_HI) begin
         pred_count[15:8] = op.data;
         pred_enable      = 1'b1;
         pred_line        = 1'b0;
      end else if (cfg_board == BOARD_SIMPLE && op.address[15]) begin
         // PRG 16K and CHR 8K switched together
         rep.update_kind = UPD_PRG16;
         rep.bank_number = {3'b000, op.data[7:3]};
         rep.update_slot = op.data[2:0];
      end else if (cfg_board == BOARD_CHRRAM && op.address[15]) begin
         if (pred_ram_mode || cfg_chr_ram) begin
            rep.update_kind = UPD_PRG16;
            rep.bank_number = {2'b00, op.data[7:2]};
            rep.update_slot = {1'b0, op.data[1:0]};
         end else begin
            rep.update_kind = UPD_CHR8;
            rep.bank_number = op.data;
         end
         rep.chr_source = pred_ram_mode;
      end else if (cfg_board == BOARD_FINE && op.address[15:2] == ADDR_PRG8_BASE) begin
         rep.update_kind = UPD_PRG8;
         rep.update_slot = {1'b0, op.address[1:0]};
         rep.bank_number = op.data;
      end else if (cfg_board == BOARD_FINE && op.address[15:3] == ADDR_CHR1_BASE) begin
         rep.update_kind = UPD_CHR1;
         rep.update_slot = op.address[2:0];
         rep.bank_number = op.data;
      end
      rep.irq_line  = pred_line;
      rep.mirroring = pred_mirror;
      return rep;
   endfunction

   // Driver: offer queued requests, predict each one at acceptance
   always @(posedge clock) begin : drive_requests
      rsp_type predicted;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predicted = predict_mapper(req_item);
            expected_reports.push_back(predicted);
         end
         if (!req_valid || req_ready) begin
            if (pending_cpu_ops.size() != 0 && !take_break()) begin
               req_item  <= pending_cpu_ops.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   // Hold off the receiver once for a long stretch so the block backs up
   always @(posedge clock) begin : hold_off
      if (reset) begin
         stall_left <= 0;
      end else if (!stall_done && reports_seen >= 700) begin
         stall_done <= 1'b1;
         stall_left <= 80;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end
   end

   // Monitor: compare each accepted result with the oldest prediction
   always @(posedge clock) begin : check_reports
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            reports_seen++;
            if (expected_reports.size() == 0) begin
               $display("%0t: unexpected result, expected none, got %h", $time, rsp_item);
               mismatches++;
            end else begin
               want = expected_reports.pop_front();
               check_field("irq_line", want.irq_line, rsp_item.irq_line);
               check_field("mirroring", want.mirroring, rsp_item.mirroring);
               check_field("update_kind", want.update_kind, rsp_item.update_kind);
               check_field("update_slot", want.update_slot, rsp_item.update_slot);
               check_field("bank_number", want.bank_number, rsp_item.bank_number);
               check_field("chr_source", want.chr_source, rsp_item.chr_source);
            end
         end
         if (stall_left != 0)
            rsp_ready <= 1'b0;
         else
            rsp_ready <= !take_break();
      end
   end

   task automatic write_csr(input logic [1:0] index, input logic [31:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      // register takes the value at this edge
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (index)
         CSR_BOARD_TYPE: cfg_board   = value[1:0];
         CSR_IRQ_TARGET: cfg_target  = value[15:0];
         CSR_CHR_IS_RAM: cfg_chr_ram = value[0];
         default: ;
      endcase
   endtask

   task automatic configure(input logic [1:0] board, input logic [15:0] target,
                            input logic chr_ram);
      write_csr(CSR_BOARD_TYPE, {30'd0, board});
      write_csr(CSR_IRQ_TARGET, {16'd0, target});
      write_csr(CSR_CHR_IS_RAM, {31'd0, chr_ram});
   endtask

   task automatic push_write(input logic [15:0] address, input logic [7:0] data);
      req_type op;
      op.mode    = MODE_WRITE;
      op.address = address;
      op.data    = data;
      pending_cpu_ops.push_back(op);
      queued_ops++;
   endtask

   // Address and data of a tick carry random junk that must be ignored
   task automatic push_tick();
      req_type op;
      op.mode    = MODE_TICK;
      op.address = 16'($urandom);
      op.data    = 8'($urandom);
      pending_cpu_ops.push_back(op);
      queued_ops++;
   endtask

   // Wait until every request is out and every result is back
   task automatic drain();
      @(negedge clock);
      while (pending_cpu_ops.size() != 0 || req_valid || expected_reports.size() != 0)
         @(negedge clock);
      repeat (3) @(posedge clock);
   endtask

   // One random request, or a short well-formed sequence
   task automatic add_random_op();
      int          pick;
      int          lead;
      logic [15:0] start;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         push_tick();
      end else if (pick < 42) begin
         // arm the counter a few ticks short of the target, then run it out
         lead  = $urandom_range(0, 12);
         start = cfg_target - 16'(lead);
         push_write(ADDR_IRQ_LO, start[7:0]);
         push_write(ADDR_IRQ_HI, start[15:8]);
         repeat (lead + 1 + $urandom_range(0, 3)) push_tick();
      end else if (pick < 47) begin
         push_write(ADDR_IRQ_EN, 8'($urandom));
      end else if (pick < 52) begin
         push_write($urandom_range(0, 1) ? ADDR_IRQ_LO : ADDR_IRQ_HI, 8'($urandom));
      end else if (pick < 60) begin
         push_write($urandom_range(0, 1) ? ADDR_MODE : ADDR_MIRROR, 8'($urandom));
      end else if (pick < 75) begin
         push_write(16'h8000 | 16'($urandom_range(0, 16'h7FFF)), 8'($urandom));
      end else if (pick < 87) begin
         push_write(16'h4500 | 16'($urandom_range(0, 31)), 8'($urandom));
      end else begin
         push_write(16'($urandom), 8'($urandom));
      end
   endtask

   initial begin : stimulus
      int          phase_size;
      int          first;
      logic [15:0] target;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // Reset defaults: simple board, no IRQ, combined switches
      push_write(16'h8000, 8'hFF);
      push_write(16'hFFFF, 8'h00);
      push_write(ADDR_IRQ_EN, 8'h01);
      push_tick();
      push_write(ADDR_MODE, 8'h90);
      push_write(ADDR_MODE, 8'h10);
      push_write(ADDR_MIRROR, 8'h10);
      drain();

      // CHR RAM board: CHR-only and combined switches, IRQ firing and clearing
      configure(BOARD_CHRRAM, 16'd2, 1'b0);
      push_write(ADDR_MODE, 8'h80);
      push_write(16'h8000, 8'hA5);
      push_write(ADDR_MODE, 8'h00);
      push_write(16'hFFFF, 8'h5A);
      push_write(ADDR_IRQ_HI, 8'h00);
      repeat (3) push_tick();
      push_write(ADDR_IRQ_LO, 8'h55);
      push_write(ADDR_IRQ_EN, 8'h00);
      drain();

      // Fine banking board, then the board with IRQ but no bank registers
      configure(BOARD_FINE, 16'hFFFF, 1'b1);
      push_write(16'h4504, 8'hFF);
      push_write(16'h4507, 8'h01);
      push_write(16'h4510, 8'h80);
      push_write(16'h4517, 8'h7F);
      push_write(16'h4508, 8'h00);
      push_write(16'h8000, 8'h33);
      drain();
      configure(2'd3, 16'd0, 1'b0);
      push_write(16'h8000, 8'h11);
      push_write(16'h4505, 8'h22);
      push_write(ADDR_IRQ_EN, 8'h01);
      push_tick();
      drain();

      // Random phases across boards and targets, extremes included
      for (int p = 0; p < 8; p++) begin
         case (p)
            1:       target = 16'h0000;
            2:       target = 16'hFFFF;
            5:       target = 16'($urandom_range(0, 40));
            default: target = 16'($urandom);
         endcase
         configure(2'(p % 4), target, p[2]);
         phase_size = $urandom_range(170, 210);
         first      = queued_ops;
         while (queued_ops - first < phase_size)
            add_random_op();
         drain();
      end

      repeat (4) @(posedge clock);
      if (mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== cartridge_bank_irq_mapper_core.f =====
hw/rtl/cbim_pkg.sv
hw/rtl/cbim_step.sv
hw/rtl/cbim_out_buf.sv
hw/rtl/cartridge_bank_irq_mapper_core.sv
hw/rtl/cbim_checker.sv
test/cartridge_bank_irq_mapper_core_tb.sv
